[sv/bitmap_block_allocator_unit_macros.svh]
// assertion macros used by the allocator datapath
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, codes and controller/datapath structs of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BOFF_W     = $clog2(WORD_BITS);
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int CFG_W      = 10;
  localparam logic [CFG_W-1:0] MAP_BYTES_RESET = 10'd512;

  typedef enum logic [2:0] {
    OP_ALLOC_ONE = 3'd0,
    OP_FREE_ONE  = 3'd1,
    OP_QUERY     = 3'd2,
    OP_ALLOC_RUN = 3'd3,
    OP_FREE_RUN  = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } st_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic word_step;
    logic chunk_step;
    logic query_ev;
    logic fill_wr;
    logic fin;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fail;
    logic is_clear;
    logic is_query;
    logic is_scan;
    logic word_adv;
    logic last_word;
    logic found;
    logic last_chunk;
    logic fill_last;
    logic res_free;
  } bba_sts_t;

endpackage

`default_nettype wire

[sv/bba_ifs.sv]
// ----------------------------------------------------------------------------
// bba_ifs
// request, response and configuration channels of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       opcode;
  logic [IDX_W-1:0] target_block;
  logic [LEN_W-1:0] run_length;
  modport source (output valid, opcode, target_block, run_length, input ready);
  modport sink (input valid, opcode, target_block, run_length, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] result_index;
  logic             is_used;
  modport source (output valid, status, result_index, is_used, input ready);
  modport sink (input valid, status, result_index, is_used, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] map_bytes;
  modport source (output valid, map_bytes, input ready);
  modport sink (input valid, map_bytes, output ready);
endinterface

`default_nettype wire

[sv/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// request sequencer: check, scan, fill, query and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire bba_sts_t sts,
  output bba_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_Q_RD  = 10'b00_0000_0100,
    S_Q_EV  = 10'b00_0000_1000,
    S_W_RD  = 10'b00_0001_0000,
    S_WORD  = 10'b00_0010_0000,
    S_CHUNK = 10'b00_0100_0000,
    S_F_RD  = 10'b00_1000_0000,
    S_F_WR  = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.fail || sts.is_clear) state_next = S_FIN;
        else if (sts.is_query) state_next = S_Q_RD;
        else if (sts.is_scan) state_next = S_W_RD;
        else state_next = S_F_RD;
      end
      S_Q_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_Q_EV;
      end
      S_Q_EV: begin
        cmd.query_ev = 1'b1;
        state_next   = S_FIN;
      end
      S_W_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WORD;
      end
      S_WORD: begin
        cmd.word_step = 1'b1;
        if (!sts.word_adv) state_next = S_CHUNK;
        else if (sts.last_word) state_next = S_FIN;
        else state_next = S_W_RD;
      end
      S_CHUNK: begin
        cmd.chunk_step = 1'b1;
        if (sts.found) state_next = S_F_RD;
        else if (sts.last_chunk && sts.last_word) state_next = S_FIN;
        else if (sts.last_chunk) state_next = S_W_RD;
      end
      S_F_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_F_WR;
      end
      S_F_WR: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = S_FIN;
        else state_next = S_F_RD;
      end
      S_FIN: begin
        if (sts.res_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/bba_dp.sv]
// ----------------------------------------------------------------------------
// bba_dp
// used-bit map memory, scan and fill datapath, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_block_allocator_unit_macros.svh"

module bba_dp import bba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bba_cmd_t         cmd,
  output bba_sts_t              sts,
  input  wire logic [2:0]       opcode,
  input  wire logic [IDX_W-1:0] target_block,
  input  wire logic [LEN_W-1:0] run_length,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output logic [1:0]            rsp_status,
  output logic [IDX_W-1:0]      rsp_index,
  output logic                  rsp_used
);

  logic [CFG_W-1:0]     map_bytes;
  op_t                  op;
  logic [IDX_W-1:0]     blk;
  logic [LEN_W-1:0]     len;
  logic [WADDR_W-1:0]   waddr;
  logic [2:0]           chunk;
  logic [LEN_W-1:0]     run;
  logic [IDX_W-1:0]     start;
  logic [IDX_W-1:0]     lo, hi;
  st_t                  pst;
  logic [IDX_W-1:0]     pidx;
  logic                 pused;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvld;

  logic [LEN_W-1:0]     total, mb8, lim;
  logic [LEN_W-1:0]     total_m1;
  logic                 bad, full;
  logic [WORD_BITS-1:0] word, inmask, eff, fmask, wdata;
  logic                 word_skip, word_jump, last_word;
  logic [LEN_W:0]       run_p64;
  logic [7:0]           cbits;
  logic [LEN_W-1:0]     r;
  logic [IDX_W-1:0]     s;
  logic                 found;
  logic [BOFF_W-1:0]    lo_off, hi_off;
  logic [IDX_W-1:0]     fend;
  logic                 fill_set;

  // blocks managed, saturating at the map size
  assign mb8   = {map_bytes, 3'b000};
  assign total = (mb8 > LEN_W'(NUM_BLOCKS)) ? LEN_W'(NUM_BLOCKS) : mb8;
  assign total_m1 = total - LEN_W'(1);

  always_comb begin
    bad  = 1'b0;
    full = 1'b0;
    case (op)
      OP_ALLOC_ONE: full = (total == '0);
      OP_FREE_ONE, OP_QUERY: bad = ({1'b0, blk} >= total);
      OP_ALLOC_RUN: bad = (len == '0) || (len > total);
      OP_FREE_RUN: bad = (len == '0) ||
                         (({2'b00, blk} + {1'b0, len}) > {1'b0, total});
      OP_CLEAR: bad = 1'b0;
      default: bad = 1'b1;
    endcase
  end

  // word as read, with blocks past the map end treated as used
  assign word   = rvld ? rdata : '0;
  assign lim    = total - {1'b0, waddr, {BOFF_W{1'b0}}};
  assign inmask = (lim >= LEN_W'(WORD_BITS)) ? '1 :
                  ((WORD_BITS'(1) << lim[BOFF_W-1:0]) - WORD_BITS'(1));
  assign eff       = word | ~inmask;
  assign word_skip = &eff;
  assign run_p64   = {1'b0, run} + (LEN_W+1)'(WORD_BITS);
  assign word_jump = (~|eff) && (run_p64 < {1'b0, len});
  assign last_word = (waddr == total_m1[IDX_W-1:BOFF_W]);

  // eight blocks of first-fit run tracking per cycle
  assign cbits = eff[{chunk, 3'b000} +: 8];
  always_comb begin
    r     = run;
    s     = start;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found) begin
        if (cbits[i]) begin
          r = '0;
        end else begin
          if (r == '0) s = {waddr, chunk, 3'(i)};
          r = r + LEN_W'(1);
          if (r == len) found = 1'b1;
        end
      end
    end
  end

  // range mask of the current word
  assign lo_off   = (lo[IDX_W-1:BOFF_W] == waddr) ? lo[BOFF_W-1:0] : '0;
  assign hi_off   = (hi[IDX_W-1:BOFF_W] == waddr) ? hi[BOFF_W-1:0] : '1;
  assign fmask    = ({WORD_BITS{1'b1}} << lo_off) &
                    ({WORD_BITS{1'b1}} >> (BOFF_W'(WORD_BITS-1) - hi_off));
  assign fill_set = (op == OP_ALLOC_ONE) || (op == OP_ALLOC_RUN);
  assign wdata    = fill_set ? (word | fmask) : (word & ~fmask);
  assign fend     = IDX_W'(({1'b0, s} + len) - LEN_W'(1));

  always_comb begin
    sts            = '0;
    sts.fail       = bad || full;
    sts.is_clear   = (op == OP_CLEAR);
    sts.is_query   = (op == OP_QUERY);
    sts.is_scan    = fill_set;
    sts.word_adv   = word_skip || word_jump;
    sts.last_word  = last_word;
    sts.found      = found;
    sts.last_chunk = (chunk == 3'd7);
    sts.fill_last  = (waddr == hi[IDX_W-1:BOFF_W]);
    sts.res_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) map_bytes <= MAP_BYTES_RESET;
    else if (cfg_we) map_bytes <= cfg_data;
  end

  // map memory, read data registered
  always_ff @(posedge clk) begin
    if (cmd.fill_wr) mem[waddr] <= wdata;
    if (cmd.rd) rdata <= mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (cmd.check && (op == OP_CLEAR)) vld <= '0;
      else if (cmd.fill_wr) vld[waddr] <= 1'b1;
      if (cmd.rd) rvld <= vld[waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(opcode);
      blk <= target_block;
      len <= ((opcode == OP_ALLOC_ONE) || (opcode == OP_FREE_ONE)) ?
             LEN_W'(1) : run_length;
    end
    if (cmd.check) begin
      pst   <= bad ? ST_INVALID : (full ? ST_FULL : ST_OK);
      pidx  <= '0;
      pused <= 1'b0;
      run   <= '0;
      start <= '0;
      chunk <= '0;
      lo    <= blk;
      hi    <= IDX_W'(({1'b0, blk} + len) - LEN_W'(1));
      waddr <= fill_set ? '0 : blk[IDX_W-1:BOFF_W];
    end
    if (cmd.query_ev) pused <= word[blk[BOFF_W-1:0]];
    if (cmd.word_step) begin
      chunk <= '0;
      if (word_skip) begin
        run <= '0;
      end else if (word_jump) begin
        if (run == '0) start <= {waddr, {BOFF_W{1'b0}}};
        run <= run_p64[LEN_W-1:0];
      end
      if (word_skip || word_jump) begin
        if (last_word) pst <= ST_FULL;
        else waddr <= waddr + WADDR_W'(1);
      end
    end
    if (cmd.chunk_step) begin
      run   <= r;
      start <= s;
      if (found) begin
        lo    <= s;
        hi    <= fend;
        pidx  <= s;
        waddr <= s[IDX_W-1:BOFF_W];
      end else if (chunk == 3'd7) begin
        if (last_word) pst <= ST_FULL;
        else waddr <= waddr + WADDR_W'(1);
      end else begin
        chunk <= chunk + 3'd1;
      end
    end
    if (cmd.fill_wr && (waddr != hi[IDX_W-1:BOFF_W])) waddr <= waddr + WADDR_W'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.fin) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      rsp_status <= pst;
      rsp_index  <= pidx;
      rsp_used   <= pused;
    end
  end

  `BBA_ASSERT_IMPL(a_no_rd_wr, cmd.rd, !cmd.fill_wr, "map read and write in one cycle")
  `BBA_ASSERT_IMPL(a_run_in_map, cmd.chunk_step && found,
    ((LEN_W+1)'(s) + (LEN_W+1)'(len)) <= (LEN_W+1)'(total), "run found past map end")
  `BBA_ASSERT_NEXT(a_fin_shows, cmd.fin, rsp_valid, "finished result not presented")

endmodule

`default_nettype wire

[sv/bitmap_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit block allocator over a used-bit map of up to 4096 blocks
// ----------------------------------------------------------------------------
// One request transaction in, one response transaction out. The map is held
// as 64 words of 64 bits in a single-port memory; clear-all and reset drop a
// per-word valid bit. A request is checked first; rejected requests and
// clear-all then go straight to the result, a query reads one map word, a
// free touches each map word of its range with a read and a write, and an
// alloc scans the map word by word, using the eight-block search step in
// each word that needs an in-word search (first free block, or the word
// where a run starts or ends), then marks the run with a read and a write
// per word. A response still held in the output register holds the next
// one back until it is taken. A finished response sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module bitmap_block_allocator_unit import bba_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);

  bba_cmd_t cmd;
  bba_sts_t sts;
  logic     req_ready;

  // map size register is always writable
  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  // sequencer
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // map, search and result datapath
  bba_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (req.opcode),
    .target_block (req.target_block),
    .run_length   (req.run_length),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.map_bytes),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_index    (rsp.result_index),
    .rsp_used     (rsp.is_used)
  );

endmodule

`default_nettype wire
